/* src/efd_pkg.sv */
// Shared types and constants for the escaped frame deframer.
`timescale 1ns / 1ps

package efd_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MARKER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK   = 3'd3;

    localparam logic [7:0] START_MARKER_RST  = 8'hAA;
    localparam logic [7:0] END_MARKER_RST    = 8'h55;
    localparam logic [7:0] ESCAPE_MARKER_RST = 8'h7D;
    localparam logic [7:0] ESCAPE_MASK_RST   = 8'h20;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SUM_BAD  = 3'd1;
    localparam logic [2:0] ST_END_BAD  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_CUT_ESC  = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  frame_kind;
        logic [15:0] payload_length;
        logic [31:0] head_word;
        logic [7:0]  sum_received;
        logic [7:0]  sum_computed;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] escape_marker;
        logic [7:0] escape_mask;
    } cfg_regs_t;

    // unstuffed byte handed from the escape stage to the parser
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data;
        logic       cut;
    } esc_out_t;

endpackage

/* src/efd_unstuff.sv */
// Escape removal: drops escape bytes and unmasks the byte after them.
`timescale 1ns / 1ps

module efd_unstuff (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  efd_pkg::in_item_t item,
    input  efd_pkg::cfg_regs_t cfg,
    output efd_pkg::esc_out_t esc
);
    import efd_pkg::*;

    logic pending_reg;
    logic pending_next;

    always_comb
    begin
        pending_next   = pending_reg;
        esc.byte_valid = 1'b0;
        esc.cut        = 1'b0;
        esc.data       = item.rx_byte;
        if (pending_reg)
        begin
            esc.byte_valid = 1'b1;
            esc.data       = item.rx_byte ^ cfg.escape_mask;
            pending_next   = 1'b0;
        end
        else if (item.rx_byte == cfg.escape_marker)
        begin
            if (item.burst_end)
                esc.cut = 1'b1;
            else
                pending_next = 1'b1;
        end
        else
        begin
            esc.byte_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else if (take)
            pending_reg <= pending_next;
    end

endmodule

/* src/efd_parser.sv */
// Frame parser: header, payload with running XOR and head word, checksum, end marker.
`timescale 1ns / 1ps

module efd_parser #(
    parameter int MAX_PAYLOAD = efd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  efd_pkg::esc_out_t  esc,
    input  efd_pkg::cfg_regs_t cfg,
    output logic               res_valid,
    output efd_pkg::out_item_t res
);
    import efd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [2:0] {
        PH_SOF,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_SUM,
        PH_EOF
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]  xor_reg, xor_next;
    logic [31:0] head_reg, head_next;
    logic [7:0]  sum_reg, sum_next;

    logic [15:0] len_full;
    logic [CNT_W:0] cnt_inc;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        head_next  = head_reg;
        sum_next   = sum_reg;
        res_valid  = 1'b0;
        res.status         = ST_OK;
        res.frame_kind     = kind_reg;
        res.payload_length = len_reg;
        res.head_word      = head_reg;
        res.sum_received   = sum_reg;
        res.sum_computed   = xor_reg;
        len_full = {len_reg[15:8], esc.data};
        cnt_inc  = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};

        if (esc.cut)
        begin
            if (phase_reg != PH_SOF)
            begin
                res_valid  = 1'b1;
                res.status = ST_CUT_ESC;
            end
            phase_next = PH_SOF;
        end
        else if (esc.byte_valid)
        begin
            case (phase_reg)
                PH_SOF:
                begin
                    if (esc.data == cfg.start_marker)
                    begin
                        kind_next  = '0;
                        len_next   = '0;
                        cnt_next   = '0;
                        xor_next   = '0;
                        head_next  = '0;
                        sum_next   = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    kind_next  = esc.data;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {esc.data, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = len_full;
                    cnt_next = '0;
                    if (len_full == 16'd0)
                        phase_next = PH_SUM;
                    else if ({1'b0, len_full} > 17'(MAX_PAYLOAD))
                    begin
                        res_valid          = 1'b1;
                        res.status         = ST_TOO_LONG;
                        res.payload_length = len_full;
                        res.sum_received   = '0;
                        res.sum_computed   = '0;
                        phase_next         = PH_SOF;
                    end
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    xor_next = xor_reg ^ esc.data;
                    if (cnt_reg < CNT_W'(4))
                        head_next = head_reg | (32'(esc.data) << {cnt_reg[1:0], 3'b000});
                    cnt_next = cnt_inc[CNT_W-1:0];
                    if (17'(cnt_inc) >= {1'b0, len_reg})
                        phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    sum_next = esc.data;
                    if (xor_reg == esc.data)
                        phase_next = PH_EOF;
                    else
                    begin
                        res_valid        = 1'b1;
                        res.status       = ST_SUM_BAD;
                        res.sum_received = esc.data;
                        phase_next       = PH_SOF;
                    end
                end
                PH_EOF:
                begin
                    res_valid  = 1'b1;
                    res.status = (esc.data == cfg.end_marker) ? ST_OK : ST_END_BAD;
                    phase_next = PH_SOF;
                end
                default:
                begin
                    phase_next = PH_SOF;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SOF;
            kind_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            xor_reg   <= '0;
            head_reg  <= '0;
            sum_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            head_reg  <= head_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

/* src/efd_out_buf.sv */
// Two-entry result buffer between the parser and the output channel.
`timescale 1ns / 1ps

module efd_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  efd_pkg::out_item_t wr_data,
    output logic               not_full,
    output logic               out_valid,
    input  logic               out_ready,
    output efd_pkg::out_item_t out_data
);
    import efd_pkg::*;

    out_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign out_valid = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign rd_en     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/escaped_frame_deframer.sv */
// Top level of the escaped frame deframer: configuration registers and datapath.
//
//   channel | direction | request contents
//   in      | input     | in_data: rx_byte, burst_end
//   out     | output    | out_data: status, kind, length, head word, both sums
//   cfg     | input     | cfg_index, cfg_data (8-bit register value)
//
// One request per cycle while in_ready is high: each byte is unstuffed and
// parsed in the cycle it is taken, and any result is registered into the
// two-entry output buffer, visible from the next cycle. in_ready drops only
// while the output buffer holds two results. rst_n clears parser state and
// restores marker and mask defaults; cfg_ready is always high.
`timescale 1ns / 1ps

module escaped_frame_deframer #(
    parameter int MAX_PAYLOAD = efd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  efd_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output efd_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [efd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data
);
    import efd_pkg::*;

    cfg_regs_t cfg_reg;
    logic      take;
    esc_out_t  esc;
    logic      res_valid;
    out_item_t res;
    logic      not_full;

    assign cfg_ready = 1'b1;
    assign in_ready  = not_full;
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker  <= START_MARKER_RST;
            cfg_reg.end_marker    <= END_MARKER_RST;
            cfg_reg.escape_marker <= ESCAPE_MARKER_RST;
            cfg_reg.escape_mask   <= ESCAPE_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_MARKER:  cfg_reg.start_marker  <= cfg_data;
                CFG_END_MARKER:    cfg_reg.end_marker    <= cfg_data;
                CFG_ESCAPE_MARKER: cfg_reg.escape_marker <= cfg_data;
                CFG_ESCAPE_MASK:   cfg_reg.escape_mask   <= cfg_data;
                default:           ;
            endcase
        end
    end

    efd_unstuff u_unstuff (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data),
        .cfg   (cfg_reg),
        .esc   (esc)
    );

    efd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .esc       (esc),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    efd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (take && res_valid),
        .wr_data   (res),
        .not_full  (not_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
